@@ hdl/mat3i_pkg.sv @@
// Shared types, widths and cofactor index tables for the 3x3 matrix inverse.
`default_nettype none
package mat3i_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;

    localparam int PROD_BITS    = 2 * WORD_BITS;
    localparam int ADJ_BITS     = 2 * WORD_BITS + 1;
    localparam int ADJ_MAG_BITS = 2 * WORD_BITS;
    localparam int PP_BITS      = 2 * WORD_BITS + 1;
    localparam int DET_BITS     = 3 * WORD_BITS + 3;
    localparam int DET_MAG_BITS = 3 * WORD_BITS + 2;
    localparam int NUM_BITS     = ADJ_MAG_BITS + 2 * FRAC_BITS;
    localparam int REM_BITS     = ((NUM_BITS - WORD_BITS) > DET_MAG_BITS ?
                                   (NUM_BITS - WORD_BITS) : DET_MAG_BITS) + 1;

    // cofactor stages, determinant stages, divide lane, output register
    localparam int LATENCY = 2 + 4 + (WORD_BITS + 1) + 1;

    typedef logic signed [WORD_BITS-1:0]  word_t;
    typedef logic        [WORD_BITS-1:0]  quo_t;
    typedef logic signed [PROD_BITS-1:0]  prod_t;
    typedef logic signed [ADJ_BITS-1:0]   adj_t;
    typedef logic        [ADJ_MAG_BITS-1:0] adj_mag_t;
    typedef logic signed [PP_BITS-1:0]    pp_t;
    typedef logic signed [DET_BITS-1:0]   det_t;
    typedef logic        [DET_MAG_BITS-1:0] det_mag_t;
    typedef logic        [NUM_BITS-1:0]   num_t;
    typedef logic        [REM_BITS-1:0]   rem_t;

    typedef struct packed {
        det_mag_t mag;
        logic     neg;
        logic     zero;
    } det_info_t;

    // adjugate element k = m[P]*m[Q] - m[R]*m[S], sides swapped when NEG is set
    localparam int ADJ_P [9] = '{4, 1, 1, 3, 0, 0, 3, 0, 0};
    localparam int ADJ_Q [9] = '{8, 8, 5, 8, 8, 5, 7, 7, 4};
    localparam int ADJ_R [9] = '{7, 7, 4, 6, 6, 3, 6, 6, 3};
    localparam int ADJ_S [9] = '{5, 2, 2, 5, 2, 2, 4, 1, 1};
    localparam bit ADJ_NEG [9] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

endpackage
`default_nettype wire

@@ hdl/matrix3_inverse_unit.sv @@
// Top level of the pipelined 3x3 fixed-point matrix inverse.
// Pipeline from start to done: 2 cofactor stages, 4 determinant stages,
// 33 divider stages and 1 output register; the 33 divider stages dominate.
// Throughput: one matrix per cycle; busy stays low and the result can't be held off.
// Reset clears every valid bit; words in flight are dropped.
`default_nettype none
module matrix3_inverse_unit
    import mat3i_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    output logic       busy,
    input  wire word_t in_r0c0,
    input  wire word_t in_r0c1,
    input  wire word_t in_r0c2,
    input  wire word_t in_r1c0,
    input  wire word_t in_r1c1,
    input  wire word_t in_r1c2,
    input  wire word_t in_r2c0,
    input  wire word_t in_r2c1,
    input  wire word_t in_r2c2,
    output logic       done,
    output word_t      out_r0c0,
    output word_t      out_r0c1,
    output word_t      out_r0c2,
    output word_t      out_r1c0,
    output word_t      out_r1c1,
    output word_t      out_r1c2,
    output word_t      out_r2c0,
    output word_t      out_r2c1,
    output word_t      out_r2c2,
    output logic       singular,
    output logic       clipped
);

    word_t      mat [9];
    logic       cof_valid;
    adj_t       adj [9];
    word_t      row0 [3];
    logic       det_valid;
    det_info_t  det;
    adj_mag_t   adj_mag [9];
    logic [8:0] adj_neg;
    quo_t       quo [9];
    logic [8:0] ovf;

    logic       valid_pipe_reg [WORD_BITS+1];
    logic       sing_pipe_reg  [WORD_BITS+1];
    logic [8:0] sign_pipe_reg  [WORD_BITS+1];

    word_t      out_reg [9];
    word_t      out_next [9];
    logic [8:0] clip_bits;
    logic       done_reg;
    logic       singular_reg;
    logic       clipped_reg;

    assign busy = 1'b0;

    assign mat[0] = in_r0c0;
    assign mat[1] = in_r0c1;
    assign mat[2] = in_r0c2;
    assign mat[3] = in_r1c0;
    assign mat[4] = in_r1c1;
    assign mat[5] = in_r1c2;
    assign mat[6] = in_r2c0;
    assign mat[7] = in_r2c1;
    assign mat[8] = in_r2c2;

    mat3i_cofactor u_cofactor (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .mat       (mat),
        .out_valid (cof_valid),
        .adj       (adj),
        .row0      (row0)
    );

    mat3i_det u_det (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cof_valid),
        .adj       (adj),
        .row0      (row0),
        .out_valid (det_valid),
        .det       (det),
        .adj_mag   (adj_mag),
        .adj_neg   (adj_neg)
    );

    for (genvar k = 0; k < 9; k++)
    begin : g_lane
        mat3i_div_lane u_div (
            .clk     (clk),
            .num_mag (adj_mag[k]),
            .den     (det.mag),
            .quo     (quo[k]),
            .ovf     (ovf[k])
        );
    end

    // carry valid, singular and result signs alongside the divider lanes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= WORD_BITS; i++)
            begin
                valid_pipe_reg[i] <= 1'b0;
            end
        end
        else
        begin
            valid_pipe_reg[0] <= det_valid;
            for (int i = 1; i <= WORD_BITS; i++)
            begin
                valid_pipe_reg[i] <= valid_pipe_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sing_pipe_reg[0] <= det.zero;
        sign_pipe_reg[0] <= adj_neg ^ {9{det.neg}};
        for (int i = 1; i <= WORD_BITS; i++)
        begin
            sing_pipe_reg[i] <= sing_pipe_reg[i-1];
            sign_pipe_reg[i] <= sign_pipe_reg[i-1];
        end
    end

    // saturate each quotient to the signed word range, then apply the sign; a singular matrix gives all zeros
    always_comb
    begin
        quo_t lim;
        quo_t mag;
        for (int k = 0; k < 9; k++)
        begin
            lim = sign_pipe_reg[WORD_BITS][k] ? {1'b1, {(WORD_BITS-1){1'b0}}}
                                              : {1'b0, {(WORD_BITS-1){1'b1}}};
            clip_bits[k] = ovf[k] || (quo[k] > lim);
            mag = clip_bits[k] ? lim : quo[k];
            if (sing_pipe_reg[WORD_BITS])
            begin
                out_next[k] = '0;
            end
            else if (sign_pipe_reg[WORD_BITS][k])
            begin
                out_next[k] = word_t'(-mag);
            end
            else
            begin
                out_next[k] = word_t'(mag);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg     <= 1'b0;
            singular_reg <= 1'b0;
            clipped_reg  <= 1'b0;
        end
        else
        begin
            done_reg     <= valid_pipe_reg[WORD_BITS];
            singular_reg <= valid_pipe_reg[WORD_BITS] && sing_pipe_reg[WORD_BITS];
            clipped_reg  <= valid_pipe_reg[WORD_BITS] && !sing_pipe_reg[WORD_BITS]
                            && (clip_bits != '0);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 9; k++)
        begin
            out_reg[k] <= out_next[k];
        end
    end

    assign done     = done_reg;
    assign singular = singular_reg;
    assign clipped  = clipped_reg;
    assign out_r0c0 = out_reg[0];
    assign out_r0c1 = out_reg[1];
    assign out_r0c2 = out_reg[2];
    assign out_r1c0 = out_reg[3];
    assign out_r1c1 = out_reg[4];
    assign out_r1c2 = out_reg[5];
    assign out_r2c0 = out_reg[6];
    assign out_r2c1 = out_reg[7];
    assign out_r2c2 = out_reg[8];

endmodule
`default_nettype wire

@@ hdl/mat3i_cofactor.sv @@
// Two-stage cofactor pipeline: 2x2 products, then the nine adjugate elements.
`default_nettype none
module mat3i_cofactor
    import mat3i_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    input  wire word_t mat [9],
    output logic       out_valid,
    output adj_t       adj [9],
    output word_t      row0 [3]
);

    logic  s1_valid_reg;
    logic  s2_valid_reg;
    prod_t prod_a_reg [9];
    prod_t prod_b_reg [9];
    word_t row0_s1_reg [3];
    word_t row0_s2_reg [3];
    adj_t  adj_reg [9];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    for (genvar k = 0; k < 9; k++)
    begin : g_elem
        always_ff @(posedge clk)
        begin
            prod_a_reg[k] <= prod_t'(mat[ADJ_P[k]]) * prod_t'(mat[ADJ_Q[k]]);
            prod_b_reg[k] <= prod_t'(mat[ADJ_R[k]]) * prod_t'(mat[ADJ_S[k]]);
            if (ADJ_NEG[k])
            begin
                adj_reg[k] <= adj_t'(prod_b_reg[k]) - adj_t'(prod_a_reg[k]);
            end
            else
            begin
                adj_reg[k] <= adj_t'(prod_a_reg[k]) - adj_t'(prod_b_reg[k]);
            end
        end
        assign adj[k] = adj_reg[k];
    end

    for (genvar j = 0; j < 3; j++)
    begin : g_row
        always_ff @(posedge clk)
        begin
            row0_s1_reg[j] <= mat[j];
            row0_s2_reg[j] <= row0_s1_reg[j];
        end
        assign row0[j] = row0_s2_reg[j];
    end

    assign out_valid = s2_valid_reg;

endmodule
`default_nettype wire

@@ hdl/mat3i_det.sv @@
// Four-stage determinant pipeline; also splits the adjugate into sign and magnitude.
`default_nettype none
module mat3i_det
    import mat3i_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    input  wire adj_t  adj [9],
    input  wire word_t row0 [3],
    output logic       out_valid,
    output det_info_t  det,
    output adj_mag_t   adj_mag [9],
    output logic [8:0] adj_neg
);

    logic      valid_reg [4];
    pp_t       pp_lo_reg [3];
    pp_t       pp_hi_reg [3];
    det_t      term_reg [3];
    det_t      det_sum_reg;
    det_info_t det_reg;
    adj_t      adj_d1_reg [9];
    adj_t      adj_d2_reg [9];
    adj_mag_t  mag_d3_reg [9];
    adj_mag_t  mag_d4_reg [9];
    logic [8:0] neg_d3_reg;
    logic [8:0] neg_d4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < 4; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    // split each 65-bit cofactor so no multiply is wider than about 32 by 33
    for (genvar j = 0; j < 3; j++)
    begin : g_term
        logic [WORD_BITS-1:0]      lo;
        logic signed [WORD_BITS:0] hi;
        assign lo = adj[3*j][WORD_BITS-1:0];
        assign hi = adj[3*j][ADJ_BITS-1:WORD_BITS];

        always_ff @(posedge clk)
        begin
            pp_lo_reg[j] <= pp_t'(row0[j]) * pp_t'($signed({1'b0, lo}));
            pp_hi_reg[j] <= pp_t'(row0[j]) * pp_t'(hi);
            term_reg[j]  <= (det_t'(pp_hi_reg[j]) <<< WORD_BITS) + det_t'(pp_lo_reg[j]);
        end
    end

    for (genvar k = 0; k < 9; k++)
    begin : g_adj
        always_ff @(posedge clk)
        begin
            adj_d1_reg[k] <= adj[k];
            adj_d2_reg[k] <= adj_d1_reg[k];
            neg_d3_reg[k] <= adj_d2_reg[k] < 0;
            mag_d3_reg[k] <= (adj_d2_reg[k] < 0) ? adj_mag_t'(-adj_d2_reg[k])
                                                  : adj_mag_t'(adj_d2_reg[k]);
            mag_d4_reg[k] <= mag_d3_reg[k];
            neg_d4_reg[k] <= neg_d3_reg[k];
        end
        assign adj_mag[k] = mag_d4_reg[k];
    end

    always_ff @(posedge clk)
    begin
        det_sum_reg  <= term_reg[0] + term_reg[1] + term_reg[2];
        det_reg.neg  <= det_sum_reg < 0;
        det_reg.zero <= det_sum_reg == '0;
        det_reg.mag  <= (det_sum_reg < 0) ? det_mag_t'(-det_sum_reg)
                                          : det_mag_t'(det_sum_reg);
    end

    assign out_valid = valid_reg[3];
    assign det       = det_reg;
    assign adj_neg   = neg_d4_reg;

endmodule
`default_nettype wire

@@ hdl/mat3i_div_lane.sv @@
// Pipelined restoring divider: one quotient bit per stage plus an overflow check.
`default_nettype none
module mat3i_div_lane
    import mat3i_pkg::*;
(
    input  wire logic     clk,
    input  wire adj_mag_t num_mag,
    input  wire det_mag_t den,
    output quo_t          quo,
    output logic          ovf
);

    num_t     num;
    rem_t     rem_reg [WORD_BITS];
    quo_t     low_reg [WORD_BITS];
    det_mag_t den_reg [WORD_BITS];
    logic     ovf_reg [WORD_BITS+1];
    quo_t     q_reg   [1:WORD_BITS];

    assign num = num_t'({num_mag, {(2*FRAC_BITS){1'b0}}});

    // a quotient of 2^WORD_BITS or more always saturates
    always_ff @(posedge clk)
    begin
        rem_reg[0] <= rem_t'(num >> WORD_BITS);
        ovf_reg[0] <= rem_t'(num >> WORD_BITS) >= rem_t'(den);
        low_reg[0] <= num[WORD_BITS-1:0];
        den_reg[0] <= den;
    end

    for (genvar i = 1; i <= WORD_BITS; i++)
    begin : g_step
        rem_t trial;
        logic ge;
        quo_t q_prev;

        assign trial = {rem_reg[i-1][REM_BITS-2:0], low_reg[i-1][WORD_BITS-i]};
        assign ge    = trial >= rem_t'(den_reg[i-1]);

        if (i == 1)
        begin : g_first
            assign q_prev = '0;
        end
        else
        begin : g_rest
            assign q_prev = q_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            q_reg[i]   <= {q_prev[WORD_BITS-2:0], ge};
            ovf_reg[i] <= ovf_reg[i-1];
        end

        if (i < WORD_BITS)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[i] <= ge ? trial - rem_t'(den_reg[i-1]) : trial;
                low_reg[i] <= low_reg[i-1];
                den_reg[i] <= den_reg[i-1];
            end
        end
    end

    assign quo = q_reg[WORD_BITS];
    assign ovf = ovf_reg[WORD_BITS];

endmodule
`default_nettype wire

@@ hdl/mat3i_checker.sv @@
// Port-level checks for the matrix inverse unit, bound to its top level.
`default_nettype none
module mat3i_checker
    import mat3i_pkg::*;
(
    input wire logic  clk,
    input wire logic  rst_n,
    input wire logic  start,
    input wire logic  busy,
    input wire logic  done,
    input wire word_t out_r0c0,
    input wire word_t out_r1c1,
    input wire word_t out_r2c2,
    input wire logic  singular,
    input wire logic  clipped
);

    a_never_busy : assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised although the pipeline never stalls");

    a_fixed_latency : assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LATENCY done)
        else $error("accepted word did not complete after the pipeline latency");

    a_no_spurious_done : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result strobe without a matching accepted word");

    a_singular_zero : assert property (@(posedge clk) disable iff (!rst_n)
        singular |-> done && !clipped && out_r0c0 == '0 && out_r1c1 == '0
                     && out_r2c2 == '0)
        else $error("singular result carries nonzero data or clip flag");

endmodule

bind matrix3_inverse_unit mat3i_checker u_mat3i_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .out_r0c0 (out_r0c0),
    .out_r1c1 (out_r1c1),
    .out_r2c2 (out_r2c2),
    .singular (singular),
    .clipped  (clipped)
);
`default_nettype wire
